// ----- sv/fsr_pkg.sv -----
// ----------------------------------------------------------------------------
// fsr_pkg: shared types and constants of the fractional step resampler
// Payload structs, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package fsr_pkg;

	localparam int SampleBits = 24;
	localparam int FracBits   = 16;
	localparam int IndexBits  = 16;
	localparam int PosBits    = IndexBits + FracBits;
	localparam int MaxResults = 48;
	// coefficient and product widths for the shared multiplier
	localparam int CoefBits   = SampleBits + 5;
	localparam int AccBits    = SampleBits + 6;

	localparam logic [1:0] RegMode  = 2'd0;
	localparam logic [1:0] RegStep  = 2'd1;
	localparam logic [1:0] RegStart = 2'd2;
	localparam logic [1:0] RegCount = 2'd3;

	localparam logic [1:0] ModePoint  = 2'd0;
	localparam logic [1:0] ModeLinear = 2'd1;

	typedef struct packed {
		logic signed [SampleBits-1:0] sample_in;
		logic                         last_in;
	} in_item_t;

	typedef struct packed {
		logic signed [SampleBits-1:0] sample_out;
		logic                         run_last;
		logic                         count_done;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  idx;
		logic [31:0] data;
	} cfg_item_t;

endpackage

// ----- sv/fsr_mac.sv -----
// ----------------------------------------------------------------------------
// fsr_mac: shared multiply, floor shift and add unit
// Computes floor(x * t / 2^FracBits) + addend, registered.
// ----------------------------------------------------------------------------
module fsr_mac (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [fsr_pkg::AccBits-1:0]  x,
	input  logic        [fsr_pkg::FracBits-1:0] t,
	input  logic signed [fsr_pkg::AccBits-1:0]  addend,
	output logic signed [fsr_pkg::AccBits-1:0]  result_q
);
	import fsr_pkg::*;

	logic signed [AccBits+FracBits:0] prod;
	logic signed [AccBits:0]          shifted;

	// arithmetic shift is a floor toward minus infinity
	assign prod    = x * $signed({1'b0, t});
	assign shifted = prod[AccBits+FracBits:FracBits];

	// hold the result between passes
	always_ff @(posedge clk) begin
		if (en)
			result_q <= AccBits'(shifted + (AccBits+1)'(addend));
	end
endmodule

// ----- sv/fractional_step_resampler_top.sv -----
// ----------------------------------------------------------------------------
// fractional_step_resampler_top: one channel fixed point resampler
// Point, linear or Catmull-Rom interpolation over a four sample history.
// ----------------------------------------------------------------------------
// Sequencing: an input is taken in S_IDLE; each result then passes S_CHECK,
// the multiplier states (none for point, S_MUL1 for linear, S_MUL1, S_MUL2
// repeated and S_MUL3 for cubic, through one shared multiplier), S_FIN and
// S_EMIT. S_FIN also waits while the sink stalls a waiting result.
// Results wait in an output register while the next one is computed.
// Reset clears history and counters and loads registers with their defaults.
module fractional_step_resampler_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  fsr_pkg::in_item_t    in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output fsr_pkg::out_item_t   out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  fsr_pkg::cfg_item_t   cfg_data
);
	import fsr_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CHECK = 7'b0000010,
		S_MUL1  = 7'b0000100,
		S_MUL2  = 7'b0001000,
		S_MUL3  = 7'b0010000,
		S_FIN   = 7'b0100000,
		S_EMIT  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [1:0]            mode_q;
	logic [23:0]           step_q;
	logic [31:0]           start_q;
	logic [15:0]           count_q;
	logic signed [SampleBits-1:0] hist_q [4];
	logic [PosBits-1:0]    pos_q;
	logic [IndexBits-1:0]  seen_q;
	logic [15:0]           made_q;
	logic                  last_q;
	logic [5:0]            k_q;
	logic [1:0]            pass_q;
	logic signed [AccBits-1:0] p1_q, c1_q, c2_q;

	logic                  out_full_q;
	out_item_t             out_q;

	logic [1:0]  la;
	logic [IndexBits-1:0] idx;
	logic [FracBits-1:0]  frac;
	logic        ready_item;
	logic [IndexBits+1:0] idx_la;
	logic signed [SampleBits-1:0] p0, p1, p2, p3;
	logic signed [AccBits-1:0] mac_x, mac_add, mac_q;
	logic        mac_en;
	logic signed [AccBits-1:0] c3;
	logic signed [AccBits-1:0] y_half;
	logic signed [SampleBits-1:0] y_sat;
	logic signed [AccBits-1:0] y_pre;
	logic signed [AccBits-1:0] sat_hi, sat_lo;

	assign la     = (mode_q == ModePoint) ? 2'd0 : ((mode_q == ModeLinear) ? 2'd1 : 2'd2);
	assign idx    = pos_q[PosBits-1:FracBits];
	assign frac   = pos_q[FracBits-1:0];
	assign idx_la = (IndexBits+2)'(idx) + (IndexBits+2)'(la);
	assign ready_item = last_q ? (idx <= seen_q) : (idx_la <= (IndexBits+2)'(seen_q));

	function automatic logic signed [SampleBits-1:0] fetch_s(
		input logic signed [IndexBits+1:0] j,
		input logic [IndexBits-1:0]        n,
		input logic signed [SampleBits-1:0] h0, h1, h2, h3
	);
		logic signed [IndexBits+2:0] d;
		logic [1:0] oldest;
		logic [1:0] sel;
		begin
			oldest = (n >= 3) ? 2'd3 : n[1:0];
			d = (IndexBits+3)'($signed({1'b0, n})) - (IndexBits+3)'(j);
			if (d < 0)
				sel = 2'd0;
			else if (d > $signed((IndexBits+3)'(oldest)))
				sel = oldest;
			else
				sel = d[1:0];
			unique case (sel)
				2'd0: fetch_s = h0;
				2'd1: fetch_s = h1;
				2'd2: fetch_s = h2;
				default: fetch_s = h3;
			endcase
		end
	endfunction

	always_comb begin
		logic signed [IndexBits+1:0] ji;
		ji = $signed({2'b00, idx});
		p0 = fetch_s((IndexBits+2)'(ji - 1), seen_q, hist_q[0], hist_q[1], hist_q[2],
			hist_q[3]);
		p1 = fetch_s(ji, seen_q, hist_q[0], hist_q[1], hist_q[2], hist_q[3]);
		p2 = fetch_s((IndexBits+2)'(ji + 1), seen_q, hist_q[0], hist_q[1], hist_q[2],
			hist_q[3]);
		p3 = fetch_s((IndexBits+2)'(ji + 2), seen_q, hist_q[0], hist_q[1], hist_q[2],
			hist_q[3]);
	end

	assign c3 = AccBits'(AccBits'(p3) - AccBits'(p0) + 3 * (AccBits'(p1) - AccBits'(p2)));

	always_comb begin
		mac_x   = c3;
		mac_add = c2_q;
		if (state_q == S_MUL1 && la == 2'd1) begin
			mac_x   = AccBits'(p2) - AccBits'(p1);
			mac_add = AccBits'(p1);
		end else if (state_q == S_MUL2) begin
			mac_x   = mac_q;
			mac_add = pass_q[0] ? (p1_q <<< 1) : c1_q;
		end
	end

	assign mac_en = (state_q == S_MUL1) || (state_q == S_MUL2);

	fsr_mac u_mac (
		.clk      (clk),
		.en       (mac_en),
		.x        (mac_x),
		.t        (frac),
		.addend   (mac_add),
		.result_q (mac_q)
	);

	assign y_half = mac_q >>> 1;
	always_comb begin
		priority if (la == 2'd0)
			y_pre = AccBits'(p1);
		else if (la == 2'd1)
			y_pre = mac_q;
		else
			y_pre = y_half;
	end
	assign sat_hi = $signed(AccBits'({1'b0, {(SampleBits-1){1'b1}}}));
	assign sat_lo = ~sat_hi;
	assign y_sat = (y_pre > sat_hi) ? sat_hi[SampleBits-1:0] :
		(y_pre < sat_lo) ? sat_lo[SampleBits-1:0] : y_pre[SampleBits-1:0];

	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign out_valid = out_full_q;
	assign out_data  = out_q;

	logic more;
	assign more = (k_q < 6'(MaxResults)) && (made_q < count_q);

	// decide at load time whether the result being loaded ends the request
	logic [PosBits-1:0]   pos_next;
	logic [IndexBits-1:0] idx_next;
	logic [IndexBits+1:0] idx_next_la;
	logic                 ready_next;
	logic                 more_next;
	assign pos_next    = pos_q + PosBits'(step_q);
	assign idx_next    = pos_next[PosBits-1:FracBits];
	assign idx_next_la = (IndexBits+2)'(idx_next) + (IndexBits+2)'(la);
	assign ready_next  = last_q ? (idx_next <= seen_q)
		: (idx_next_la <= (IndexBits+2)'(seen_q));
	assign more_next   = (k_q + 6'd1 < 6'(MaxResults)) && (made_q + 16'd1 < count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= ModeLinear;
			step_q     <= 24'd65536;
			start_q    <= '0;
			count_q    <= 16'd1024;
			for (int i = 0; i < 4; i++) hist_q[i] <= '0;
			pos_q      <= '0;
			seen_q     <= '0;
			made_q     <= '0;
			last_q     <= 1'b0;
			k_q        <= '0;
			pass_q     <= '0;
			p1_q       <= '0;
			c1_q       <= '0;
			c2_q       <= '0;
			out_q      <= '0;
			out_full_q <= 1'b0;
		end else begin
			if (out_full_q && out_ready)
				out_full_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						unique case (cfg_data.idx)
							RegMode:  mode_q <= cfg_data.data[1:0];
							RegStep:  step_q <= cfg_data.data[23:0];
							RegStart: begin
								start_q <= cfg_data.data;
								if (seen_q == '0)
									pos_q <= PosBits'(cfg_data.data);
							end
							default:  count_q <= cfg_data.data[15:0];
						endcase
					end else if (in_valid) begin
						hist_q[3] <= hist_q[2];
						hist_q[2] <= hist_q[1];
						hist_q[1] <= hist_q[0];
						hist_q[0] <= in_data.sample_in;
						last_q    <= in_data.last_in;
						k_q       <= '0;
						state_q   <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (more && ready_item) begin
						pass_q  <= '0;
						p1_q    <= AccBits'(p1) <<< 0;
						c1_q    <= AccBits'(p2) - AccBits'(p0);
						c2_q    <= AccBits'(2 * AccBits'(p0) - 5 * AccBits'(p1)
							+ 4 * AccBits'(p2) - AccBits'(p3));
						state_q <= (la == 2'd0) ? S_FIN : S_MUL1;
					end else if (!(out_full_q && !out_ready)) begin
						// hold here until the last result of the request leaves
						if (last_q) begin
							for (int i = 0; i < 4; i++) hist_q[i] <= '0;
							pos_q  <= PosBits'(start_q);
							seen_q <= '0;
							made_q <= '0;
						end else begin
							seen_q <= seen_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_MUL1: state_q <= (la == 2'd1) ? S_FIN : S_MUL2;
				S_MUL2: begin
					pass_q  <= pass_q + 1'b1;
					state_q <= pass_q[0] ? S_MUL3 : S_MUL2;
				end
				S_MUL3: state_q <= S_FIN;
				S_FIN: begin
					if (!out_full_q || out_ready) begin
						out_q.sample_out <= y_sat;
						out_q.run_last   <= !(more_next && ready_next);
						out_q.count_done <= (made_q + 1'b1) == count_q;
						out_full_q <= 1'b1;
						made_q     <= made_q + 1'b1;
						pos_q      <= pos_next;
						k_q        <= k_q + 1'b1;
						state_q    <= S_EMIT;
					end
				end
				S_EMIT: state_q <= S_CHECK;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_full_q && !out_ready) |=> state_q == S_FIN)
		else $error("result overwritten while waiting");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> k_q <= 6'(MaxResults))
		else $error("result cap exceeded");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && (!out_full_q || out_ready)) |=> out_full_q)
		else $error("result not loaded");
endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: resampler interpolation check
// Drives source samples and register writes, predicts every interpolated
// output from its own copy of history and read position, compares in order.
// ----------------------------------------------------------------------------
class resample_scoreboard;
	logic [1:0]  mode;
	logic [23:0] step;
	logic [31:0] start_pos;
	logic [15:0] out_count;
	longint      hist [4];
	logic [31:0] read_pos;
	logic [15:0] seen;
	logic [15:0] made;
	fsr_pkg::out_item_t pending_q [$];
	int          errors;

	function new();
		mode = fsr_pkg::ModeLinear;
		step = 24'd65536;
		start_pos = '0;
		out_count = 16'd1024;
		errors = 0;
		restart();
	endfunction

	function void restart();
		for (int k = 0; k < 4; k++) hist[k] = 0;
		read_pos = start_pos;
		seen = '0;
		made = '0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [31:0] val);
		case (idx)
			fsr_pkg::RegMode: mode = val[1:0];
			fsr_pkg::RegStep: step = val[23:0];
			fsr_pkg::RegStart: begin
				start_pos = val;
				if (seen == 0) read_pos = val;
			end
			default: out_count = val[15:0];
		endcase
	endfunction

	function longint floor_frac(longint v);
		return v >>> fsr_pkg::FracBits;
	endfunction

	function longint neighbor(longint j, longint n);
		longint oldest, d;
		oldest = n >= 3 ? 3 : n;
		d = n - j;
		if (d < 0) d = 0;
		if (d > oldest) d = oldest;
		return hist[d];
	endfunction

	// note an accepted request and queue the outputs it causes
	function void note_sample(fsr_pkg::in_item_t it);
		longint n, lead, idx, t, y, p0, p1, p2, p3, c1, c2, c3, a, b, sum;
		int k;
		fsr_pkg::out_item_t r;
		n = seen;
		lead = mode == fsr_pkg::ModePoint ? 0 : (mode == fsr_pkg::ModeLinear ? 1 : 2);
		k = 0;
		hist[3] = hist[2]; hist[2] = hist[1]; hist[1] = hist[0];
		hist[0] = longint'(it.sample_in);
		while (k < fsr_pkg::MaxResults && made < out_count) begin
			idx = read_pos[31:16];
			t = read_pos[15:0];
			if (it.last_in ? (idx > n) : (idx + lead > n)) break;
			if (lead == 0) y = neighbor(idx, n);
			else if (lead == 1) begin
				p0 = neighbor(idx, n);
				p1 = neighbor(idx + 1, n);
				y = p0 + floor_frac((p1 - p0) * t);
			end else begin
				p0 = neighbor(idx - 1, n);
				p1 = neighbor(idx, n);
				p2 = neighbor(idx + 1, n);
				p3 = neighbor(idx + 2, n);
				c1 = p2 - p0;
				c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
				c3 = -p0 + 3 * p1 - 3 * p2 + p3;
				a = floor_frac(c3 * t) + c2;
				b = floor_frac(a * t) + c1;
				sum = floor_frac(b * t) + 2 * p1;
				y = sum >>> 1;
			end
			if (y > 8388607) y = 8388607;
			if (y < -8388608) y = -8388608;
			made = made + 16'd1;
			read_pos = read_pos + {8'd0, step};
			r.sample_out = y[23:0];
			r.run_last = 1'b0;
			r.count_done = made == out_count;
			pending_q.push_back(r);
			k++;
		end
		if (k > 0) pending_q[pending_q.size() - 1].run_last = 1'b1;
		if (it.last_in) restart();
		else seen = seen + 16'd1;
	endfunction

	function void report(string what);
		$display("MISMATCH %s at %0t", what, $time);
		errors++;
	endfunction

	function void check_output(fsr_pkg::out_item_t got);
		fsr_pkg::out_item_t exp_r;
		if (pending_q.size() == 0) begin
			report($sformatf("unexpected output %h", got));
			return;
		end
		exp_r = pending_q.pop_front();
		if (got.sample_out !== exp_r.sample_out)
			report($sformatf("sample_out %h exp %h", got.sample_out, exp_r.sample_out));
		if (got.run_last !== exp_r.run_last)
			report($sformatf("run_last %b exp %b", got.run_last, exp_r.run_last));
		if (got.count_done !== exp_r.count_done)
			report($sformatf("count_done %b exp %b", got.count_done, exp_r.count_done));
	endfunction
endclass

module tb_top;
	import fsr_pkg::*;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	in_item_t  in_data;
	out_item_t out_data;
	cfg_item_t cfg_data;
	resample_scoreboard sb;
	bit calm;
	longint cycles;

	fractional_step_resampler_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 3000000) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// sink with random stalls
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_output(out_data);
		out_ready <= calm || ($urandom_range(99) >= 11);
	end

	// valid stays up after a request so back to back requests need one update
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_data <= '{idx: idx, data: val};
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
	endtask

	task automatic send(logic signed [23:0] s, logic l);
		cfg_valid <= 1'b0;
		while (!calm && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_data <= '{sample_in: s, last_in: l};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_sample('{sample_in: s, last_in: l});
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (sb.pending_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (400) @(posedge clk);
	endtask

	function automatic logic signed [23:0] rand_sample();
		case ($urandom_range(5))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			default: return 24'($urandom());
		endcase
	endfunction

	initial begin
		logic [1:0] m;
		int len;
		sb = new();
		calm = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0; cfg_valid = 1'b0;
		in_data = '0; cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults first, then directed extremes
		send(24'sh7FFFFF, 1'b0); send(24'sh800000, 1'b0);
		send(24'sh000001, 1'b0); send(24'shFFFFFF, 1'b1);
		drain();
		for (int md = 0; md < 4; md++) begin
			write_reg(RegMode, 32'(md));
			write_reg(RegStep, md == 0 ? 32'd4096 : 32'd40000);
			write_reg(RegStart, md == 3 ? 32'h0001_8000 : 32'h0000_4000);
			write_reg(RegCount, 32'd65535);
			send(24'sh7FFFFF, 1'b0); send(24'sh800000, 1'b0);
			send(24'sh7FFFFF, 1'b0); send(24'sh123456, 1'b1);
			drain();
		end
		// count reached mid run, then huge step and far start
		write_reg(RegCount, 32'd3);
		write_reg(RegStep, 32'h00FF_FFFF);
		for (int i = 0; i < 4; i++) send(rand_sample(), i == 3);
		drain();
		write_reg(RegCount, 32'd0);
		write_reg(RegStart, 32'hFFFF_FFFF);
		send(24'sh000005, 1'b1);
		drain();

		// random runs
		for (int run = 0; run < 24; run++) begin
			calm = run >= 8 && run < 12;
			m = $urandom_range(3);
			write_reg(RegMode, 32'(m));
			write_reg(RegStep, $urandom_range(3) == 0 ? $urandom_range(24'hFFFFFF, 4096)
				: $urandom_range(24'h20000, 4096));
			write_reg(RegStart, $urandom_range(3) == 0 ? $urandom()
				: $urandom_range(32'h0003_FFFF));
			write_reg(RegCount, $urandom_range(7) == 0 ? $urandom_range(8)
				: $urandom_range(16'hFFFF, 100));
			len = $urandom_range(10, 2);
			for (int i = 0; i < len; i++) send(rand_sample(), i == len - 1);
			drain();
		end
		calm = 1'b0;
		drain();
		if (sb.errors == 0 && sb.pending_q.size() == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end
endmodule
